### sv/wvdv_pkg.sv
// ----------------------------------------------------------------------------
// wvdv_pkg
// Shared types, constants and lookup functions for the wind vane vote block.
// ----------------------------------------------------------------------------
package wvdv_pkg;

   localparam int NUM_SECTORS    = 8;
   localparam int SECTOR_BITS    = 3;
   localparam int CODE_BITS      = 5;
   localparam int DIR_BITS       = 4;
   localparam int HEADING_BITS   = 9;
   localparam int SAMPLE_BITS    = 8;
   localparam int VOTES_OUT_BITS = 8;

   localparam logic [DIR_BITS-1:0]     SECTOR_NONE    = 4'd8;
   localparam logic [SAMPLE_BITS-1:0]  SPR_RESET      = 8'd5;
   localparam logic [SAMPLE_BITS-1:0]  SAMPLE_MAX     = 8'd255;
   localparam logic [HEADING_BITS-1:0] DEG_PER_SECTOR = 9'd45;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LOAD
   } state_type;

   // Sequencer commands to the scan unit
   typedef struct packed {
      logic start;
      logic step;
   } scan_ctrl_type;

   // Scan unit status back to the sequencer
   typedef struct packed {
      logic                   last;
      logic                   found;
      logic [SECTOR_BITS-1:0] sector;
   } scan_stat_type;

   // Encoder code to compass sector, SECTOR_NONE for codes with no sector
   function automatic logic [DIR_BITS-1:0] sector_of(input logic [CODE_BITS-1:0] code);
      logic [DIR_BITS-1:0] s;
      case (code)
         5'd1:    s = 4'd1;
         5'd2:    s = 4'd7;
         5'd3:    s = 4'd0;
         5'd4:    s = 4'd6;
         5'd5:    s = 4'd0;
         5'd6:    s = 4'd6;
         5'd8:    s = 4'd4;
         5'd9:    s = 4'd4;
         5'd10:   s = 4'd7;
         5'd12:   s = 4'd4;
         5'd14:   s = 4'd6;
         5'd15:   s = 4'd0;
         5'd16:   s = 4'd3;
         5'd17:   s = 4'd1;
         5'd18:   s = 4'd2;
         5'd19:   s = 4'd1;
         5'd20:   s = 4'd6;
         5'd21:   s = 4'd5;
         5'd22:   s = 4'd2;
         5'd23:   s = 4'd2;
         5'd24:   s = 4'd3;
         5'd26:   s = 4'd7;
         5'd27:   s = 4'd3;
         5'd29:   s = 4'd5;
         5'd30:   s = 4'd6;
         default: s = SECTOR_NONE;
      endcase
      return s;
   endfunction

   function automatic logic [HEADING_BITS-1:0] heading_of(
      input logic [SECTOR_BITS-1:0] sector);
      return HEADING_BITS'(sector) * DEG_PER_SECTOR;
   endfunction

endpackage

### sv/wind_vane_direction_vote.sv
// ----------------------------------------------------------------------------
// wind_vane_direction_vote
// Votes encoder readings into eight compass sectors and reports the leader.
// ----------------------------------------------------------------------------
// Each request is one 5-bit encoder reading. When it is taken, the
// matching sector counter and the sample count advance, and if the report
// threshold is not reached the next request is accepted in the following
// cycle. A reading that reaches csr samples_per_report (reset 5; 0 reports
// on every reading) starts a scan: one comparator walks the eight sector
// counters, one per cycle, then the result is loaded into the output
// register and all counters clear. A reporting request therefore occupies
// the block through its accept, 8 scan steps and load, and longer if the
// previous result is still held by rsp_stall. Ties go to the lower sector;
// with no votes the result is direction 8, heading 0, found 0, votes 0.
module wind_vane_direction_vote #(
   parameter int COUNT_BITS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [wvdv_pkg::SAMPLE_BITS-1:0]     csr_wr_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [wvdv_pkg::CODE_BITS-1:0]       req_line_code,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [wvdv_pkg::DIR_BITS-1:0]        rsp_direction,
   output logic [wvdv_pkg::HEADING_BITS-1:0]    rsp_heading_degrees,
   output logic                                 rsp_found,
   output logic [wvdv_pkg::VOTES_OUT_BITS-1:0]  rsp_winner_votes
);

   localparam int WIDE_BITS = (COUNT_BITS > wvdv_pkg::VOTES_OUT_BITS) ?
                              COUNT_BITS : wvdv_pkg::VOTES_OUT_BITS;

   wvdv_pkg::state_type              state_ff, state_in;
   logic [wvdv_pkg::SAMPLE_BITS-1:0] spr_ff, spr_in;
   logic [wvdv_pkg::SAMPLE_BITS-1:0] samples_ff, samples_in;
   logic [COUNT_BITS-1:0]            votes_ff [wvdv_pkg::NUM_SECTORS];
   logic [COUNT_BITS-1:0]            votes_in [wvdv_pkg::NUM_SECTORS];

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [wvdv_pkg::DIR_BITS-1:0]       rsp_dir_ff, rsp_dir_in;
   logic [wvdv_pkg::HEADING_BITS-1:0]   rsp_head_ff, rsp_head_in;
   logic                                rsp_found_ff, rsp_found_in;
   logic [wvdv_pkg::VOTES_OUT_BITS-1:0] rsp_votes_ff, rsp_votes_in;

   wvdv_pkg::scan_ctrl_type          scan_ctrl;
   wvdv_pkg::scan_stat_type          scan_stat;
   logic [COUNT_BITS-1:0]            scan_best;
   logic [WIDE_BITS-1:0]             best_wide;

   logic                             accept;
   logic                             load;
   logic [wvdv_pkg::DIR_BITS-1:0]    sector;
   logic [wvdv_pkg::SAMPLE_BITS-1:0] samples_next;
   logic                             report;

   assign accept = req_valid && !req_stall;
   assign sector = wvdv_pkg::sector_of(req_line_code);
   assign samples_next = (samples_ff == wvdv_pkg::SAMPLE_MAX) ? samples_ff :
                         samples_ff + 1'b1;
   assign report = (samples_next >= spr_ff);

   wvdv_scan #(
      .COUNT_BITS (COUNT_BITS)
   ) u_scan (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (scan_ctrl),
      .counts (votes_ff),
      .stat   (scan_stat),
      .best   (scan_best)
   );

   // sequencer
   always_comb begin
      state_in       = state_ff;
      req_stall      = 1'b1;
      scan_ctrl      = '0;
      load           = 1'b0;
      case (state_ff)
         wvdv_pkg::ST_IDLE: begin
            req_stall       = 1'b0;
            scan_ctrl.start = accept;
            if (accept && report) begin
               state_in = wvdv_pkg::ST_SCAN;
            end
         end
         wvdv_pkg::ST_SCAN: begin
            scan_ctrl.step = 1'b1;
            if (scan_stat.last) begin
               state_in = wvdv_pkg::ST_LOAD;
            end
         end
         wvdv_pkg::ST_LOAD: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || !rsp_stall) begin
               load     = 1'b1;
               state_in = wvdv_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wvdv_pkg::ST_IDLE;
         end
      endcase
   end

   // counters and configuration
   always_comb begin
      spr_in     = csr_wr_en ? csr_wr_data : spr_ff;
      samples_in = samples_ff;
      for (int i = 0; i < wvdv_pkg::NUM_SECTORS; i++) begin
         votes_in[i] = votes_ff[i];
         if (load) begin
            votes_in[i] = '0;
         end else if (accept && sector == wvdv_pkg::DIR_BITS'(i) && votes_ff[i] != '1) begin
            votes_in[i] = votes_ff[i] + 1'b1;
         end
      end
      if (load) begin
         samples_in = '0;
      end else if (accept) begin
         samples_in = samples_next;
      end
   end

   // output register
   always_comb begin
      best_wide    = WIDE_BITS'(scan_best);
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_dir_in   = rsp_dir_ff;
      rsp_head_in  = rsp_head_ff;
      rsp_found_in = rsp_found_ff;
      rsp_votes_in = rsp_votes_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = scan_stat.found;
         if (scan_stat.found) begin
            rsp_dir_in   = wvdv_pkg::DIR_BITS'(scan_stat.sector);
            rsp_head_in  = wvdv_pkg::heading_of(scan_stat.sector);
            rsp_votes_in = (best_wide > WIDE_BITS'(wvdv_pkg::SAMPLE_MAX)) ?
                           wvdv_pkg::VOTES_OUT_BITS'(wvdv_pkg::SAMPLE_MAX) :
                           best_wide[wvdv_pkg::VOTES_OUT_BITS-1:0];
         end else begin
            rsp_dir_in   = wvdv_pkg::SECTOR_NONE;
            rsp_head_in  = '0;
            rsp_votes_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wvdv_pkg::ST_IDLE;
         spr_ff       <= wvdv_pkg::SPR_RESET;
         samples_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < wvdv_pkg::NUM_SECTORS; i++) begin
            votes_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         spr_ff       <= spr_in;
         samples_ff   <= samples_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < wvdv_pkg::NUM_SECTORS; i++) begin
            votes_ff[i] <= votes_in[i];
         end
      end
      rsp_dir_ff   <= rsp_dir_in;
      rsp_head_ff  <= rsp_head_in;
      rsp_found_ff <= rsp_found_in;
      rsp_votes_ff <= rsp_votes_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_direction       = rsp_dir_ff;
   assign rsp_heading_degrees = rsp_head_ff;
   assign rsp_found           = rsp_found_ff;
   assign rsp_winner_votes    = rsp_votes_ff;

endmodule

### sv/wvdv_scan.sv
// ----------------------------------------------------------------------------
// wvdv_scan
// Single comparator stepped over the sector counters to find the leader.
// ----------------------------------------------------------------------------
module wvdv_scan #(
   parameter int COUNT_BITS = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  wvdv_pkg::scan_ctrl_type   ctrl,
   input  logic [COUNT_BITS-1:0]     counts [wvdv_pkg::NUM_SECTORS],
   output wvdv_pkg::scan_stat_type   stat,
   output logic [COUNT_BITS-1:0]     best
);

   logic [wvdv_pkg::SECTOR_BITS-1:0] idx_ff, idx_in;
   logic [wvdv_pkg::SECTOR_BITS-1:0] win_ff, win_in;
   logic                             found_ff, found_in;
   logic [COUNT_BITS-1:0]            best_ff, best_in;
   logic [COUNT_BITS-1:0]            cur;

   assign cur = counts[idx_ff];

   always_comb begin
      idx_in   = idx_ff;
      win_in   = win_ff;
      found_in = found_ff;
      best_in  = best_ff;
      if (ctrl.start) begin
         idx_in   = '0;
         found_in = 1'b0;
         best_in  = '0;
      end else if (ctrl.step) begin
         // strict compare keeps the lower sector on a tie
         if (cur > best_ff) begin
            best_in  = cur;
            win_in   = idx_ff;
            found_in = 1'b1;
         end
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         found_ff <= 1'b0;
         best_ff  <= '0;
      end else begin
         idx_ff   <= idx_in;
         found_ff <= found_in;
         best_ff  <= best_in;
      end
      win_ff <= win_in;
   end

   assign stat.last   = (idx_ff == wvdv_pkg::SECTOR_BITS'(wvdv_pkg::NUM_SECTORS - 1));
   assign stat.found  = found_ff;
   assign stat.sector = win_ff;
   assign best        = best_ff;

endmodule

### sim/wind_vane_direction_vote_tb.sv
// ----------------------------------------------------------------------------
// wind_vane_direction_vote_tb
// Self-checking testbench for the wind vane direction vote block.
// ----------------------------------------------------------------------------
// Encoder readings are sent in random bursts while the result side stalls on
// its own random pattern. A scoreboard object predicts every report from its
// own copy of the sector table, vote counters and report interval, and checks
// each report field by field against the oldest prediction. The run covers
// directed tie, unknown-code and no-vote cases, report intervals from 0 to
// 255, lowering the interval below the running count, and one long result
// hold-off that backs the block up into its request side.
// ----------------------------------------------------------------------------
module wind_vane_direction_vote_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VOTE_BITS          = 8;
   localparam int DEGREES_PER_SECTOR = 45;
   localparam int HOLD_CYCLES        = 240;
   localparam int SETTLE_CYCLES      = 16;
   localparam int CYCLE_LIMIT        = 400000;

   localparam bit [wvdv_pkg::DIR_BITS-1:0]    NO_SECTOR    = wvdv_pkg::SECTOR_NONE;
   localparam bit [VOTE_BITS-1:0]             VOTE_MAX     = {VOTE_BITS{1'b1}};
   localparam bit [wvdv_pkg::SAMPLE_BITS-1:0] SAMPLE_LIMIT = {wvdv_pkg::SAMPLE_BITS{1'b1}};

   // Encoder code to compass sector
   localparam bit [wvdv_pkg::DIR_BITS-1:0] CODE_SECTOR [32] = '{
      NO_SECTOR, 4'd1, 4'd7, 4'd0, 4'd6, 4'd0, 4'd6, NO_SECTOR,
      4'd4, 4'd4, 4'd7, NO_SECTOR, 4'd4, NO_SECTOR, 4'd6, 4'd0,
      4'd3, 4'd1, 4'd2, 4'd1, 4'd6, 4'd5, 4'd2, 4'd2,
      4'd3, NO_SECTOR, 4'd7, 4'd3, NO_SECTOR, 4'd5, 4'd6, NO_SECTOR
   };

   typedef struct packed {
      logic [wvdv_pkg::DIR_BITS-1:0]       direction;
      logic [wvdv_pkg::HEADING_BITS-1:0]   heading;
      logic                                found;
      logic [wvdv_pkg::VOTES_OUT_BITS-1:0] votes;
   } vane_report_type;

   typedef enum int {
      FLOW_FREE,
      FLOW_LIGHT,
      FLOW_HEAVY
   } flow_mode_type;

   class vane_report_board;
      bit [VOTE_BITS-1:0]             sector_votes [wvdv_pkg::NUM_SECTORS];
      bit [wvdv_pkg::SAMPLE_BITS-1:0] readings;
      bit [wvdv_pkg::SAMPLE_BITS-1:0] interval;
      vane_report_type                expected_q [$];
      int                             mismatches;
      int                             reports_checked;
      int                             readings_noted;

      function new();
         interval = wvdv_pkg::SPR_RESET;
         clear_tally();
      endfunction

      function void clear_tally();
         foreach (sector_votes[i]) sector_votes[i] = '0;
         readings = '0;
      endfunction

      function void set_interval(bit [wvdv_pkg::SAMPLE_BITS-1:0] value);
         interval = value;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Tally one accepted reading and predict the report it triggers, if any
      function void note_reading(bit [wvdv_pkg::CODE_BITS-1:0] code);
         bit [wvdv_pkg::DIR_BITS-1:0] sector;
         bit [VOTE_BITS-1:0]          best;
         int                          win;
         vane_report_type             want;
         sector = CODE_SECTOR[code];
         readings_noted++;
         if (sector != NO_SECTOR && sector_votes[sector] != VOTE_MAX) begin
            sector_votes[sector]++;
         end
         if (readings != SAMPLE_LIMIT) begin
            readings++;
         end
         if (readings < interval) return;
         best = '0;
         win  = NO_SECTOR;
         // strict compare: ties stay with the lower sector
         for (int i = 0; i < wvdv_pkg::NUM_SECTORS; i++) begin
            if (sector_votes[i] > best) begin
               best = sector_votes[i];
               win  = i;
            end
         end
         if (win != NO_SECTOR) begin
            want.direction = wvdv_pkg::DIR_BITS'(win);
            want.heading   = wvdv_pkg::HEADING_BITS'(win * DEGREES_PER_SECTOR);
            want.found     = 1'b1;
            want.votes     = (best > 255) ? 8'd255 : wvdv_pkg::VOTES_OUT_BITS'(best);
         end else begin
            want.direction = NO_SECTOR;
            want.heading   = '0;
            want.found     = 1'b0;
            want.votes     = '0;
         end
         expected_q.push_back(want);
         clear_tally();
      endfunction

      function void check_report(vane_report_type got);
         vane_report_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("[%0t] unexpected report: dir %0d hdg %0d found %0d votes %0d",
                        $realtime, got.direction, got.heading, got.found, got.votes);
            end
            return;
         end
         want = expected_q.pop_front();
         reports_checked++;
         if (got.direction !== want.direction || got.heading !== want.heading ||
             got.found !== want.found || got.votes !== want.votes) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("[%0t] report %0d: expected dir %0d hdg %0d found %0d votes %0d",
                        $realtime, reports_checked, want.direction, want.heading,
                        want.found, want.votes);
               $display("[%0t] report %0d:   actual dir %0d hdg %0d found %0d votes %0d",
                        $realtime, reports_checked, got.direction, got.heading,
                        got.found, got.votes);
            end
         end
      endfunction
   endclass

   logic                                clock         = 1'b0;
   logic                                reset         = 1'b1;
   logic                                csr_wr_en     = 1'b0;
   logic [wvdv_pkg::SAMPLE_BITS-1:0]    csr_wr_data   = '0;
   logic                                req_valid     = 1'b0;
   logic                                req_stall;
   logic [wvdv_pkg::CODE_BITS-1:0]      req_line_code = '0;
   logic                                rsp_valid;
   logic                                rsp_stall     = 1'b0;
   logic [wvdv_pkg::DIR_BITS-1:0]       rsp_direction;
   logic [wvdv_pkg::HEADING_BITS-1:0]   rsp_heading_degrees;
   logic                                rsp_found;
   logic [wvdv_pkg::VOTES_OUT_BITS-1:0] rsp_winner_votes;

   vane_report_board tally = new();

   int            cycle_count  = 0;
   int            hold_ticket  = 0;
   int            hold_served  = 0;
   int            hold_left    = 0;
   int            flow_left    = 0;
   flow_mode_type flow_mode    = FLOW_FREE;

   wind_vane_direction_vote #(
      .COUNT_BITS(VOTE_BITS)
   ) u_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_line_code       (req_line_code),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_direction       (rsp_direction),
      .rsp_heading_degrees (rsp_heading_degrees),
      .rsp_found           (rsp_found),
      .rsp_winner_votes    (rsp_winner_votes)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d reports outstanding",
                  cycle_count, tally.pending());
         $display("wind_vane_direction_vote: mismatch");
         $finish;
      end
   end

   // Result side stall: random flow modes, plus one long hold when requested
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_served != hold_ticket) begin
         hold_served <= hold_ticket;
         hold_left   <= HOLD_CYCLES;
         rsp_stall   <= 1'b1;
      end else begin
         if (flow_left == 0) begin
            flow_mode <= flow_mode_type'($urandom_range(0, 2));
            flow_left <= $urandom_range(16, 96);
         end else begin
            flow_left <= flow_left - 1;
         end
         case (flow_mode)
            FLOW_FREE:  rsp_stall <= 1'b0;
            FLOW_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            default:    rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         tally.check_report({rsp_direction, rsp_heading_degrees, rsp_found,
                             rsp_winner_votes});
      end
   end

   // Offer one reading and hold it until the block takes it
   task automatic drive_reading(input bit [wvdv_pkg::CODE_BITS-1:0] code);
      req_valid     <= 1'b1;
      req_line_code <= code;
      do @(posedge clock); while (req_stall);
      tally.note_reading(code);
   endtask

   // Wait out every pending report and the scan of any reading in flight
   task automatic settle_reports();
      while (tally.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_report_interval(input bit [wvdv_pkg::SAMPLE_BITS-1:0] value);
      settle_reports();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tally.set_interval(value);
   endtask

   // Mostly a steady vane with jitter between two codes, the rest noise
   function automatic bit [wvdv_pkg::CODE_BITS-1:0] pick_code(
      bit [wvdv_pkg::CODE_BITS-1:0] steady_a,
      bit [wvdv_pkg::CODE_BITS-1:0] steady_b);
      if ($urandom_range(0, 9) < 6) begin
         return ($urandom_range(0, 1) == 0) ? steady_a : steady_b;
      end
      return wvdv_pkg::CODE_BITS'($urandom_range(0, 31));
   endfunction

   task automatic run_vane_phase(input int count);
      bit [wvdv_pkg::CODE_BITS-1:0] steady_a;
      bit [wvdv_pkg::CODE_BITS-1:0] steady_b;
      int                           burst_left;
      steady_a   = wvdv_pkg::CODE_BITS'($urandom_range(0, 31));
      steady_b   = wvdv_pkg::CODE_BITS'($urandom_range(0, 31));
      burst_left = $urandom_range(1, 24);
      for (int n = 0; n < count; n++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 8)) @(posedge clock);
            end
         end
         drive_reading(pick_code(steady_a, steady_b));
         burst_left--;
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      bit [wvdv_pkg::CODE_BITS-1:0] directed_codes [$];
      // groups of five at the reset interval: unknowns only, a tie, one vote
      // among unknowns, a clean sweep, and the highest sector
      directed_codes = '{5'd0, 5'd7, 5'd11, 5'd13, 5'd31,
                         5'd3, 5'd16, 5'd16, 5'd3, 5'd25,
                         5'd28, 5'd28, 5'd28, 5'd30, 5'd0,
                         5'd29, 5'd21, 5'd29, 5'd21, 5'd29,
                         5'd2, 5'd10, 5'd26, 5'd26, 5'd1};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_codes[i]) drive_reading(directed_codes[i]);
      req_valid <= 1'b0;

      // report on every reading; back the block up with a long result hold
      write_report_interval(8'd0);
      hold_ticket <= hold_ticket + 1;
      run_vane_phase(80);

      write_report_interval(8'd1);
      run_vane_phase(60);

      // longest interval, leaving a partial tally behind
      write_report_interval(8'd255);
      run_vane_phase(300);

      // drop below the running count: the next reading reports at once
      write_report_interval(8'd20);
      run_vane_phase(100);

      write_report_interval(8'd2);
      run_vane_phase(80);
      write_report_interval(8'd3);
      run_vane_phase(80);

      repeat (5) begin
         write_report_interval(wvdv_pkg::SAMPLE_BITS'($urandom_range(0, 16)));
         run_vane_phase(80);
      end

      settle_reports();
      $display("sent %0d encoder readings and checked %0d direction reports",
               tally.readings_noted, tally.reports_checked);
      $display("report intervals 0 to 255, lowered mid-tally, with one long result hold");
      if (tally.mismatches == 0 && tally.pending() == 0) begin
         $display("wind_vane_direction_vote: match");
      end else begin
         $display("%0d mismatches, %0d reports outstanding",
                  tally.mismatches, tally.pending());
         $display("wind_vane_direction_vote: mismatch");
      end
      $finish;
   end

endmodule
